// File: design/rtx_pkg.sv
// ----------------------------------------------------------------------------
// rtx_pkg: shared types and constants
// Command and status bundles between controller and datapath, register
// indexes and character constants of the radix text converter.
// ----------------------------------------------------------------------------
package rtx_pkg;

    localparam int NUM_W     = 32;
    localparam int CHAR_W    = 8;
    localparam int RADIX_W   = 6;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int ALPHA_N   = 32;
    localparam int ALPHA_W   = 5;
    localparam int BITCNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_LOW   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_HIGH  = 8'd127;

    typedef struct packed {
        logic load;
        logic chk_next;
        logic div_clear;
        logic div_step;
        logic store;
        logic rd;
        logic push_sign;
        logic push_digit;
    } rtx_cmd_t;

    typedef struct packed {
        logic range_ok;
        logic char_bad;
        logic chk_last;
        logic neg;
        logic div_last;
        logic mag_zero;
        logic digits_full;
        logic count_zero;
        logic out_free;
    } rtx_status_t;

endpackage

// File: design/rtx_num_if.sv
// ----------------------------------------------------------------------------
// rtx_num_if: input number channel
// Valid/ready channel carrying one signed integer per beat.
// ----------------------------------------------------------------------------
interface rtx_num_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

// File: design/rtx_char_if.sv
// ----------------------------------------------------------------------------
// rtx_char_if: output character channel
// Valid/ready channel carrying one text character and a last flag per beat.
// ----------------------------------------------------------------------------
interface rtx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// File: design/signed_int_to_radix_text.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text: signed integer to text in a configurable radix
// Prints each input number as an optional minus sign followed by digits
// from a configured alphabet, most significant first.
// ----------------------------------------------------------------------------
//  channel  dir  per beat                         accepted when
//  num_ch   in   number (32, signed)              valid && ready
//  text_ch  out  text_char (8), last_char (1)     valid && ready
//  cfg      in   cfg_index (3), cfg_data (64)     cfg_we
//
// A number is taken, its alphabet is checked one character at a time up to the
// radix, a minus sign goes out for a negative number, then each digit comes from
// the bit-serial divider and the buffered digit characters are sent out, most
// significant first.
// Reset clears all configuration, which leaves it invalid: numbers are taken
// and dropped until a valid alphabet and radix are written.
// A stalled output holds the sequencer; a new number is taken while the final
// character still waits in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text #(
    parameter int MAX_RADIX  = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    rtx_num_if.sink                       num_ch,
    rtx_char_if.source                    text_ch,
    input  logic                          cfg_we,
    input  logic [rtx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtx_pkg::CFG_W-1:0]     cfg_data
);
    import rtx_pkg::*;

    rtx_cmd_t    cmd;
    rtx_status_t status;
    logic        in_ready;
    logic        out_valid;
    logic [CHAR_W-1:0] out_char;
    logic        out_last;

    rtx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (num_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rtx_datapath #(
        .MAX_RADIX  (MAX_RADIX),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .number    (num_ch.number),
        .cmd       (cmd),
        .status    (status),
        .out_ready (text_ch.ready),
        .out_valid (out_valid),
        .text_char (out_char),
        .last_char (out_last)
    );

    assign num_ch.ready      = in_ready;
    assign text_ch.valid     = out_valid;
    assign text_ch.text_char = out_char;
    assign text_ch.last_char = out_last;

endmodule

// File: design/rtx_datapath.sv
// ----------------------------------------------------------------------------
// rtx_datapath: configuration, check, divider, digit buffer and output
// Holds the alphabet and radix registers, checks the alphabet one character
// per cycle, divides the magnitude bit by bit and buffers digit characters.
// ----------------------------------------------------------------------------
module rtx_datapath #(
    parameter int MAX_RADIX  = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rtx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtx_pkg::CFG_W-1:0]        cfg_data,
    input  logic [rtx_pkg::NUM_W-1:0]        number,
    input  rtx_pkg::rtx_cmd_t                cmd,
    output rtx_pkg::rtx_status_t             status,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [rtx_pkg::CHAR_W-1:0]       text_char,
    output logic                             last_char
);
    import rtx_pkg::*;

    localparam int CHK_W = (MAX_RADIX > 1) ? $clog2(MAX_RADIX) : 1;
    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int ND_W  = $clog2(MAX_DIGITS + 1);

    logic [CFG_W-1:0]   alpha_reg [4];
    logic [RADIX_W-1:0] radix_reg;

    logic [CHAR_W-1:0]  alpha_chars [ALPHA_N];

    logic [CHK_W-1:0]   chk_idx_reg;
    logic [NUM_W-1:0]   mag_reg;
    logic [RADIX_W-1:0] rem_reg;
    logic               neg_reg;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [ND_W-1:0]    count_reg;
    logic [CHAR_W-1:0]  dig_mem [MAX_DIGITS];
    logic [CHAR_W-1:0]  rd_data_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;

    logic [CHAR_W-1:0]  chk_char;
    logic               chk_forbid;
    logic               chk_dup;
    logic [RADIX_W:0]   rem_sh;
    logic               rem_ge;
    logic [RADIX_W-1:0] rem_next;
    logic [NUM_W-1:0]   mag_next;
    logic [NUM_W-1:0]   load_mag;
    logic [AW-1:0]      rd_addr;

    always_comb
    begin
        for (int k = 0; k < ALPHA_N; k++)
        begin
            alpha_chars[k] = alpha_reg[k / 8][(k % 8) * 8 +: 8];
        end
    end

    // Configuration registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < 4; w++)
            begin
                alpha_reg[w] <= '0;
            end
            radix_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALPHA0: alpha_reg[0] <= cfg_data;
                CFG_ALPHA1: alpha_reg[1] <= cfg_data;
                CFG_ALPHA2: alpha_reg[2] <= cfg_data;
                CFG_ALPHA3: alpha_reg[3] <= cfg_data;
                CFG_RADIX:  radix_reg    <= cfg_data[RADIX_W-1:0];
                default:    ;
            endcase
        end
    end

    // The character under check is compared against every later character
    // in use at once.
    always_comb
    begin
        chk_char   = alpha_chars[ALPHA_W'(chk_idx_reg)];
        chk_forbid = (chk_char == CH_PLUS) || (chk_char == CH_MINUS) ||
                     (chk_char < CH_LOW) || (chk_char >= CH_HIGH);
        chk_dup    = 1'b0;
        for (int j = 0; j < MAX_RADIX; j++)
        begin
            if ((RADIX_W'(j) > RADIX_W'(chk_idx_reg)) && (RADIX_W'(j) < radix_reg) &&
                (alpha_chars[j] == chk_char))
            begin
                chk_dup = 1'b1;
            end
        end
    end

    // One restoring division step: the magnitude register shifts out the
    // dividend and shifts in quotient bits.
    always_comb
    begin
        rem_sh   = {rem_reg, mag_reg[NUM_W-1]};
        rem_ge   = rem_sh >= {1'b0, radix_reg};
        rem_next = rem_ge ? RADIX_W'(rem_sh - {1'b0, radix_reg}) : rem_sh[RADIX_W-1:0];
        mag_next = {mag_reg[NUM_W-2:0], rem_ge};
        load_mag = number[NUM_W-1] ? (~number + 32'd1) : number;
        rd_addr  = AW'(count_reg - ND_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg     <= load_mag;
            neg_reg     <= number[NUM_W-1];
            chk_idx_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cmd.chk_next)
            begin
                chk_idx_reg <= chk_idx_reg + CHK_W'(1);
            end
            if (cmd.div_step)
            begin
                mag_reg <= mag_next;
            end
            if (cmd.store)
            begin
                count_reg <= count_reg + ND_W'(1);
            end
            else if (cmd.rd)
            begin
                count_reg <= count_reg - ND_W'(1);
            end
        end

        if (cmd.div_clear)
        begin
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + BITCNT_W'(1);
        end
    end

    // Digit buffer: filled least significant digit first, read back in reverse.
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            dig_mem[AW'(count_reg)] <= alpha_chars[rem_reg[ALPHA_W-1:0]];
        end
        if (cmd.rd)
        begin
            rd_data_reg <= dig_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_sign || cmd.push_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_sign)
        begin
            out_char_reg <= CH_MINUS;
            out_last_reg <= 1'b0;
        end
        else if (cmd.push_digit)
        begin
            out_char_reg <= rd_data_reg;
            out_last_reg <= (count_reg == '0);
        end
    end

    always_comb
    begin
        status.range_ok    = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        status.char_bad    = chk_forbid || chk_dup;
        status.chk_last    = (RADIX_W'(chk_idx_reg) + RADIX_W'(1)) == radix_reg;
        status.neg         = neg_reg;
        status.div_last    = bit_cnt_reg == BITCNT_W'(NUM_W - 1);
        status.mag_zero    = mag_reg == '0;
        status.digits_full = count_reg == ND_W'(MAX_DIGITS);
        status.count_zero  = count_reg == '0;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign text_char = out_char_reg;
    assign last_char = out_last_reg;

endmodule

// File: design/rtx_ctrl.sv
// ----------------------------------------------------------------------------
// rtx_ctrl: sequencing state machine
// Steps one number through alphabet check, sign output, digit division, and readout of
// the buffered digits, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module rtx_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rtx_pkg::rtx_status_t status,
    output rtx_pkg::rtx_cmd_t    cmd
);
    import rtx_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_NEXT  = 3'd5;
    localparam logic [2:0] S_READ  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // A bad configuration drops the number without any output.
                if (!status.range_ok || status.char_bad)
                begin
                    state_next = S_IDLE;
                end
                else if (status.chk_last)
                begin
                    if (status.neg)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        cmd.div_clear = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    cmd.chk_next = 1'b1;
                end
            end
            S_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.push_sign = 1'b1;
                    cmd.div_clear = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                // At least one digit is produced, so zero prints as one digit.
                if (status.mag_zero || status.digits_full)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    cmd.div_clear = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.push_digit = 1'b1;
                    state_next     = status.count_zero ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: radix text converter check
// Loads a series of digit alphabets and radixes (valid ones and broken ones),
// feeds signed numbers through the input channel and compares every output
// character and last flag against an in-bench prediction of the text.
// ----------------------------------------------------------------------------
module testbench;
    import rtx_pkg::*;

    localparam int MAX_RADIX      = 32;
    localparam int MAX_DIGITS     = 32;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int ITEMS          = 460;
    localparam int QUIET_ITEMS    = 30;
    localparam int SETTLE_CYCLES  = 1300;
    localparam int LONG_HOLD      = 3000;
    localparam int HOLD_AT_BEAT   = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum int {
        FAULT_NONE,
        FAULT_RADIX_LOW,
        FAULT_RADIX_HIGH,
        FAULT_PLUS,
        FAULT_MINUS,
        FAULT_CTRL,
        FAULT_HIGH_CHAR,
        FAULT_REPEAT
    } alpha_fault_e;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 num_valid = 1'b0;
    logic signed [31:0]   num_value = '0;
    logic                 text_ready = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Shadow of the configuration registers as the block should hold them.
    logic [CFG_W-1:0]   alpha_word [4] = '{default: '0};
    logic [RADIX_W-1:0] radix_q = '0;
    logic [CHAR_W-1:0]  staged_chars [ALPHA_N];

    logic signed [31:0] pending_numbers [$];
    text_beat_t         text_due [$];

    int send_gap       = 0;
    int recv_gap       = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int text_beats     = 0;
    int err_count      = 0;
    int stall_cycles   = 0;
    int issued         = 0;
    bit long_hold_done = 1'b0;

    rtx_num_if  num_ch ();
    rtx_char_if text_ch ();

    assign num_ch.valid   = num_valid;
    assign num_ch.number  = num_value;
    assign text_ch.ready  = text_ready;

    signed_int_to_radix_text #(
        .MAX_RADIX  (MAX_RADIX),
        .MAX_DIGITS (MAX_DIGITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_ch    (num_ch),
        .text_ch   (text_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [CHAR_W-1:0] alpha_at(input int k);
        return alpha_word[k / 8][8 * (k % 8) +: 8];
    endfunction

    function automatic bit alphabet_ok();
        logic [CHAR_W-1:0] c;
        if (radix_q < 2 || radix_q > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < radix_q; i++)
        begin
            c = alpha_at(i);
            if (c == CH_PLUS || c == CH_MINUS || c < CH_LOW || c >= CH_HIGH)
                return 1'b0;
            for (int j = i + 1; j < radix_q; j++)
                if (alpha_at(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queues the characters one number should turn into.
    function automatic void predict_text(input logic signed [31:0] value);
        logic [63:0]       mag;
        logic [CHAR_W-1:0] digit_chars [$];
        text_beat_t        beat;
        if (!alphabet_ok())
            return;
        mag = {{32{value[31]}}, value};
        if (value[31])
        begin
            // Negating the widened value keeps the most negative input exact.
            mag = -mag;
            beat.ch = CH_MINUS;
            beat.last = 1'b0;
            text_due.push_back(beat);
        end
        if (mag == 0)
            digit_chars.push_front(alpha_at(0));
        while (mag != 0 && digit_chars.size() < MAX_DIGITS)
        begin
            digit_chars.push_front(alpha_at(int'(mag % 64'(radix_q))));
            mag = mag / 64'(radix_q);
        end
        foreach (digit_chars[k])
        begin
            beat.ch = digit_chars[k];
            beat.last = (k == digit_chars.size() - 1);
            text_due.push_back(beat);
        end
    endfunction

    function automatic logic signed [31:0] pick_number();
        logic [31:0] v;
        logic [15:0] half;
        half = 16'($urandom);
        case ($urandom_range(0, 5))
            0, 1:    v = $urandom;
            2:       v = $urandom_range(0, 600) - 300;
            3:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                              : 32'h8000_0000 + $urandom_range(0, 3);
            4:       v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: v = {{16{half[15]}}, half};
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx <= CFG_ALPHA3)
            alpha_word[idx - CFG_ALPHA0] = data;
        else if (idx == CFG_RADIX)
            radix_q = data[RADIX_W-1:0];
    endtask

    // Writes the staged alphabet and the given radix; upper radix bits are junk.
    task automatic write_alphabet(input int n);
        logic [CFG_W-1:0] word;
        for (int w = 0; w < 4; w++)
        begin
            for (int k = 0; k < 8; k++)
                word[8 * k +: 8] = staged_chars[8 * w + k];
            write_reg(CFG_IDX_W'(CFG_ALPHA0 + w), word);
        end
        if ($urandom_range(0, 2) == 0)
            for (int idx = CFG_RADIX + 1; idx < 2 ** CFG_IDX_W; idx++)
                write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
        word = {$urandom, $urandom};
        word[RADIX_W-1:0] = RADIX_W'(n);
        write_reg(CFG_RADIX, word);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic stage_string(input string s);
        for (int k = 0; k < ALPHA_N; k++)
            staged_chars[k] = (k < s.len()) ? s[k] : CHAR_W'($urandom);
    endtask

    task automatic random_setup(input alpha_fault_e fault);
        logic [CHAR_W-1:0] pool [$];
        logic [CHAR_W-1:0] tmp;
        int j, n, p, q;
        for (int c = CH_LOW; c < CH_HIGH; c++)
            if (c != CH_PLUS && c != CH_MINUS)
                pool.push_back(CHAR_W'(c));
        for (int k = 0; k < ALPHA_N; k++)
        begin
            j = $urandom_range(k, pool.size() - 1);
            tmp = pool[j];
            pool[j] = pool[k];
            pool[k] = tmp;
            staged_chars[k] = tmp;
        end
        case ($urandom_range(0, 3))
            0:       n = 2;
            1:       n = MAX_RADIX;
            default: n = $urandom_range(2, MAX_RADIX);
        endcase
        // Characters past the radix are never looked at, so they may be anything.
        for (int k = n; k < ALPHA_N; k++)
            staged_chars[k] = CHAR_W'($urandom);
        p = $urandom_range(0, n - 1);
        case (fault)
            FAULT_RADIX_LOW:  n = $urandom_range(0, 1);
            FAULT_RADIX_HIGH: n = $urandom_range(MAX_RADIX + 1, 2 ** RADIX_W - 1);
            FAULT_PLUS:       staged_chars[p] = CH_PLUS;
            FAULT_MINUS:      staged_chars[p] = CH_MINUS;
            FAULT_CTRL:       staged_chars[p] = CHAR_W'($urandom_range(0, CH_LOW - 1));
            FAULT_HIGH_CHAR:  staged_chars[p] = CHAR_W'($urandom_range(CH_HIGH, 255));
            FAULT_REPEAT:
            begin
                q = (p + $urandom_range(1, n - 1)) % n;
                staged_chars[p] = staged_chars[q];
            end
            default: ;
        endcase
        write_alphabet(n);
    endtask

    // Waits until every number is taken and every character is back, then
    // lets a dropped number finish inside the block.
    task automatic settle();
        while (pending_numbers.size() != 0 || num_valid || text_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_numbers(input logic signed [31:0] list [$]);
        foreach (list[k])
            pending_numbers.push_back(list[k]);
        settle();
    endtask

    task automatic queue_random(input int count, input bit counted);
        for (int k = 0; k < count; k++)
            pending_numbers.push_back(pick_number());
        if (counted)
            issued += count;
        settle();
    endtask

    initial
    begin
        alpha_fault_e fault;
        int           n;
        send_idle_pct = 15;
        recv_idle_pct = 15;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset leaves the alphabet invalid: these numbers must vanish.
        queue_numbers('{32'sd0, -32'sd1, 32'sh8000_0000});

        stage_string("0123456789");
        write_alphabet(10);
        queue_numbers('{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                        32'sd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                        32'sd1000000000, -32'sd999999999, 32'sh5555_5555,
                        32'shAAAA_AAAA, 32'sd65536});

        stage_string("01");
        write_alphabet(2);
        queue_numbers('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1});

        // Widest alphabet: the space up to the at sign, skipping the signs, then the tilde.
        n = 0;
        for (int c = CH_LOW; n < ALPHA_N - 1; c++)
            if (c != CH_PLUS && c != CH_MINUS)
            begin
                staged_chars[n] = CHAR_W'(c);
                n++;
            end
        staged_chars[ALPHA_N - 1] = CH_HIGH - 1;
        write_alphabet(MAX_RADIX);
        queue_numbers('{32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF});
        issued = 25;

        while (issued < ITEMS - QUIET_ITEMS)
        begin
            send_idle_pct = 8 * $urandom_range(0, 3);
            recv_idle_pct = 8 * $urandom_range(0, 3);
            fault = FAULT_NONE;
            if ($urandom_range(0, 3) == 0)
                fault = alpha_fault_e'($urandom_range(FAULT_RADIX_LOW, FAULT_REPEAT));
            random_setup(fault);
            if (fault == FAULT_NONE)
                queue_random($urandom_range(8, 24), 1'b1);
            else
                queue_random($urandom_range(3, 6), 1'b1);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_setup(FAULT_NONE);
        queue_random(QUIET_ITEMS, 1'b1);

        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            num_valid <= 1'b0;
            send_gap  <= 0;
        end
        else if (!num_valid || num_ch.ready)
        begin
            if (send_gap > 0)
            begin
                send_gap  <= send_gap - 1;
                num_valid <= 1'b0;
            end
            else if ($urandom_range(1, 100) <= send_idle_pct)
            begin
                send_gap  <= $urandom_range(1, 18) - 1;
                num_valid <= 1'b0;
            end
            else if (pending_numbers.size() != 0)
            begin
                num_valid <= 1'b1;
                num_value <= pending_numbers.pop_front();
            end
            else
                num_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_ready <= 1'b0;
            recv_gap   <= 0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap   <= recv_gap - 1;
            text_ready <= 1'b0;
        end
        else if (!long_hold_done && text_beats >= HOLD_AT_BEAT)
        begin
            // One long hold while numbers keep coming, so the input backs up.
            long_hold_done <= 1'b1;
            recv_gap       <= LONG_HOLD - 1;
            text_ready     <= 1'b0;
        end
        else if ($urandom_range(1, 100) <= recv_idle_pct)
        begin
            recv_gap   <= $urandom_range(1, 18) - 1;
            text_ready <= 1'b0;
        end
        else
            text_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        text_beat_t due;
        if (rst_n)
        begin
            if (num_ch.valid && num_ch.ready)
                predict_text(num_ch.number);
            if (text_ch.valid && text_ch.ready)
            begin
                text_beats <= text_beats + 1;
                if (text_due.size() == 0)
                begin
                    $error("text_char: expected none, got 8'h%02h", text_ch.text_char);
                    err_count++;
                end
                else
                begin
                    due = text_due.pop_front();
                    if (text_ch.text_char !== due.ch)
                    begin
                        $error("text_char: expected 8'h%02h, got 8'h%02h",
                               due.ch, text_ch.text_char);
                        err_count++;
                    end
                    if (text_ch.last_char !== due.last)
                    begin
                        $error("last_char: expected %0b, got %0b",
                               due.last, text_ch.last_char);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

// File: filelist.f
design/rtx_pkg.sv
design/rtx_num_if.sv
design/rtx_char_if.sv
design/rtx_datapath.sv
design/rtx_ctrl.sv
design/signed_int_to_radix_text.sv
tb/testbench.sv
